// ----- src/g6d_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the graph6 stream decoder
// no dependencies; imported by every other file of the block but g6d_fifo

package g6d_pkg;

	// fixed width of the count and edge result fields
	localparam int CNT_W = 36;

	// adjacency bits carried by one body byte
	localparam int BITS_PER_BYTE = 6;

	// printable graph6 range and header escape
	localparam logic [7:0] BYTE_BIAS  = 8'd63;
	localparam logic [7:0] BYTE_TILDE = 8'd126;
	localparam logic [7:0] BYTE_SPACE = 8'd32;
	localparam logic [7:0] BYTE_TAB   = 8'd9;
	localparam logic [7:0] BYTE_CR    = 8'd13;

	// header groups left after the escape bytes (short form: after its first group too)
	localparam logic [2:0] SHORT_LEFT = 3'd2;
	localparam logic [2:0] LONG_LEFT  = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_COUNT = 2'd0;
	localparam logic [1:0] KIND_EDGE  = 2'd1;
	localparam logic [1:0] KIND_BAD   = 2'd2;

	// work codes passed from front to back
	localparam logic [1:0] OP_HEADER = 2'd0;
	localparam logic [1:0] OP_BODY   = 2'd1;
	localparam logic [1:0] OP_BAD    = 2'd2;

	typedef struct packed {
		logic [1:0]       op;
		logic [CNT_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [CNT_W-1:0] vertex_count;
		logic [CNT_W-1:0] edge_row;
		logic [CNT_W-1:0] edge_column;
		logic             last;
	} res_t;

endpackage

// ----- src/g6d_fifo.sv -----
`timescale 1ns / 1ps
// small flop-based first-in first-out queue, generic width and depth
// no dependencies

module g6d_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (level_q == LVL_W'(DEPTH));
	assign empty   = (level_q == '0);
	assign push_ok = push & ~full;
	assign pop_ok  = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push_ok && !pop_ok) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop_ok && !push_ok) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- src/g6d_front.sv -----
`timescale 1ns / 1ps
// front end: takes stream bytes, drops whitespace, flags bad bytes,
// decodes the vertex-count header, forwards body bytes; depends on g6d_pkg

module g6d_front #(
	parameter int VERTEX_BITS = 36
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    byte_value,
	input  logic          start_graph,
	output g6d_pkg::cmd_t cmd,
	output logic          cmd_push,
	input  logic          cmd_full
);

	import g6d_pkg::*;

	localparam logic [2:0] PH_FIRST       = 3'd0;
	localparam logic [2:0] PH_AFTER_TILDE = 3'd1;
	localparam logic [2:0] PH_MID         = 3'd2;
	localparam logic [2:0] PH_LONG        = 3'd3;
	localparam logic [2:0] PH_BODY        = 3'd4;

	localparam logic [CNT_W-1:0] VMAX = {CNT_W{1'b1}} >> (CNT_W - VERTEX_BITS);

	logic [2:0]       phase_q, phase_e, phase_d;
	logic [2:0]       left_q, left_e, left_d, left_dec;
	logic [CNT_W-1:0] acc_q, acc_e, acc_d, acc_shift, acc_sat;
	logic             accept;
	logic             is_ws;
	logic             is_bad;
	logic [5:0]       v;

	function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] n);
		sat_count = ((n >> VERTEX_BITS) != '0) ? VMAX : n;
	endfunction

	assign full   = cmd_full;
	assign accept = push & ~cmd_full;

	always_comb begin
		// start of a new graph wipes the header state before this byte
		phase_e   = start_graph ? PH_FIRST : phase_q;
		left_e    = start_graph ? 3'd0 : left_q;
		acc_e     = start_graph ? '0 : acc_q;
		is_ws     = (byte_value == BYTE_SPACE) ||
		            ((byte_value >= BYTE_TAB) && (byte_value <= BYTE_CR));
		is_bad    = (byte_value < BYTE_BIAS) || (byte_value > BYTE_TILDE);
		v         = 6'(byte_value - BYTE_BIAS);
		acc_shift = {acc_e[CNT_W-7:0], v};
		acc_sat   = sat_count(acc_shift);
		left_dec  = (left_e != 3'd0) ? left_e - 3'd1 : 3'd0;

		phase_d   = phase_e;
		left_d    = left_e;
		acc_d     = acc_e;
		cmd_push  = 1'b0;
		cmd.op    = OP_BAD;
		cmd.value = '0;

		if (accept && !is_ws) begin
			if (is_bad) begin
				cmd_push = 1'b1;
			end else begin
				case (phase_e)
					PH_FIRST: begin
						if (byte_value == BYTE_TILDE) begin
							phase_d = PH_AFTER_TILDE;
						end else begin
							phase_d   = PH_BODY;
							acc_d     = sat_count(CNT_W'(v));
							cmd_push  = 1'b1;
							cmd.op    = OP_HEADER;
							cmd.value = sat_count(CNT_W'(v));
						end
					end
					PH_AFTER_TILDE: begin
						if (byte_value == BYTE_TILDE) begin
							phase_d = PH_LONG;
							left_d  = LONG_LEFT;
							acc_d   = '0;
						end else begin
							phase_d = PH_MID;
							left_d  = SHORT_LEFT;
							acc_d   = CNT_W'(v);
						end
					end
					PH_MID, PH_LONG: begin
						acc_d  = acc_shift;
						left_d = left_dec;
						if (left_dec == 3'd0) begin
							phase_d   = PH_BODY;
							acc_d     = acc_sat;
							cmd_push  = 1'b1;
							cmd.op    = OP_HEADER;
							cmd.value = acc_sat;
						end
					end
					PH_BODY: begin
						cmd_push  = 1'b1;
						cmd.op    = OP_BODY;
						cmd.value = CNT_W'(v);
					end
					default: begin
						phase_d = PH_FIRST;
						left_d  = 3'd0;
						acc_d   = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			left_q  <= 3'd0;
			acc_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
		end
	end

endmodule

// ----- src/g6d_back.sv -----
`timescale 1ns / 1ps
// back end: turns queued work into results, walks six adjacency bits
// of a body byte one per cycle while the result queue has room; depends on g6d_pkg

module g6d_back #(
	parameter int VERTEX_BITS = 36
) (
	input  logic          clk,
	input  logic          arst_n,
	input  g6d_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	output g6d_pkg::res_t res,
	output logic          res_push,
	input  logic          res_full
);

	import g6d_pkg::*;

	localparam int         VB        = VERTEX_BITS;
	localparam int         VBP       = VERTEX_BITS + 1;
	localparam logic [2:0] LAST_STEP = 3'(BITS_PER_BYTE - 1);
	localparam logic [2:0] SAT6      = 3'(BITS_PER_BYTE);

	logic          busy_q;
	logic [2:0]    step_q;
	logic [5:0]    bits_q;
	logic [VB-1:0] row_q, col_q, total_q;

	logic          active;
	logic [1:0]    op;
	logic [5:0]    cur_bits;
	logic [2:0]    cur_step;
	logic          col_ok;
	logic [VB-1:0] span;
	logic [VBP-1:0] col_p1, col_p2;
	logic          next_ok, next2_ok;
	logic [2:0]    span_sat, col1_sat;
	logic [4:0]    reach;
	logic [4:0]    win;
	logic          later;
	logic          emit;
	logic          need_push;
	logic          go;

	always_comb begin
		active   = busy_q | ~cmd_empty;
		op       = busy_q ? OP_BODY : cmd.op;
		cur_bits = busy_q ? bits_q : cmd.value[5:0];
		cur_step = busy_q ? step_q : 3'd0;

		// walk position is live while the column is below the vertex count
		col_ok   = (col_q < total_q);
		span     = col_q - row_q;
		col_p1   = {1'b0, col_q} + VBP'(1);
		col_p2   = {1'b0, col_q} + VBP'(2);
		next_ok  = (col_p1 < {1'b0, total_q});
		next2_ok = (col_p2 < {1'b0, total_q});
		span_sat = (span >= VB'(BITS_PER_BYTE)) ? SAT6 : span[2:0];
		col1_sat = (col_p1 >= VBP'(BITS_PER_BYTE)) ? SAT6 : col_p1[2:0];

		// live steps left from here, each term capped at one byte worth
		reach = {2'b0, span_sat} +
		        (next_ok ? ({2'b0, col1_sat} + (next2_ok ? 5'(BITS_PER_BYTE) : 5'd0))
		                 : 5'd0);
		for (int o = 1; o < BITS_PER_BYTE; o++) begin
			win[BITS_PER_BYTE - 1 - o] = (5'(o) < reach);
		end
		later = |(cur_bits[4:0] & win);

		emit      = (op == OP_BODY) && col_ok && cur_bits[5];
		need_push = (op == OP_HEADER) || (op == OP_BAD) || emit;
		go        = active && (!need_push || !res_full);
		cmd_pop   = go & ~busy_q;
		res_push  = go & need_push;

		res.kind         = KIND_BAD;
		res.vertex_count = '0;
		res.edge_row     = '0;
		res.edge_column  = '0;
		res.last         = 1'b1;
		case (op)
			OP_HEADER: begin
				res.kind         = KIND_COUNT;
				res.vertex_count = cmd.value;
			end
			OP_BODY: begin
				res.kind        = KIND_EDGE;
				res.edge_row    = CNT_W'(row_q);
				res.edge_column = CNT_W'(col_q);
				res.last        = ~later;
			end
			default: begin
				res.kind = KIND_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= 3'd0;
			row_q   <= '0;
			col_q   <= VB'(1);
			total_q <= '0;
		end else if (go) begin
			case (op)
				OP_HEADER: begin
					total_q <= cmd.value[VB-1:0];
					row_q   <= '0;
					col_q   <= VB'(1);
				end
				OP_BODY: begin
					if (col_ok) begin
						if (span == VB'(1)) begin
							row_q <= '0;
							col_q <= col_q + VB'(1);
						end else begin
							row_q <= row_q + VB'(1);
						end
					end
					busy_q <= (cur_step != LAST_STEP);
					step_q <= cur_step + 3'd1;
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go && op == OP_BODY) begin
			bits_q <= {cur_bits[4:0], 1'b0};
		end
	end

endmodule

// ----- src/graph6_stream_decoder_core.sv -----
`timescale 1ns / 1ps
// graph6 stream decoder, top level; depends on g6d_pkg, g6d_fifo,
// g6d_front and g6d_back
// a taken word passes through the work queue and then the result queue before
// its first result shows on the outputs
// the front end takes a new word while the work queue has room, before the back
// end is through with the last; a body word is walked one adjacency bit per step
// reset: arst_n clears both queues, header state and walk counters at once

module graph6_stream_decoder_core #(
	parameter int VERTEX_BITS = 36,
	parameter int CMD_DEPTH   = 4,
	parameter int RES_DEPTH   = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// input side, queue style
	input  logic        push,
	output logic        full,
	input  logic [7:0]  byte_value,
	input  logic        start_graph,
	// result side, queue style
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [35:0] vertex_count,
	output logic [35:0] edge_row,
	output logic [35:0] edge_column,
	output logic        last_of_run
);

	import g6d_pkg::*;

	// front end to work queue
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;

	// back end to result queue
	res_t res_in;
	res_t res_out;
	logic res_push;
	logic res_full;

	// front: classifies each word and decodes the header, one word a cycle while the work queue has room
	g6d_front #(
		.VERTEX_BITS(VERTEX_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.byte_value (byte_value),
		.start_graph(start_graph),
		.cmd        (cmd_in),
		.cmd_push   (cmd_push),
		.cmd_full   (cmd_full)
	);

	// work queue decouples header handling from the slower body walk
	g6d_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wr_data(cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rd_data(cmd_out),
		.empty  (cmd_empty)
	);

	// back: one result per cycle at most, edges walked in column order
	g6d_back #(
		.VERTEX_BITS(VERTEX_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res      (res_in),
		.res_push (res_push),
		.res_full (res_full)
	);

	// result queue lets the back end run on while the consumer stalls, until it fills
	g6d_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wr_data(res_in),
		.full   (res_full),
		.pop    (pop),
		.rd_data(res_out),
		.empty  (empty)
	);

	assign result_kind  = res_out.kind;
	assign vertex_count = res_out.vertex_count;
	assign edge_row     = res_out.edge_row;
	assign edge_column  = res_out.edge_column;
	assign last_of_run  = res_out.last;

endmodule

// ----- dv/tb_graph6_stream_decoder_core.sv -----
`timescale 1ns / 1ps
// self-checking testbench for graph6_stream_decoder_core: graph6 byte streams in,
// count, edge and bad-byte words checked against a cycle-free decoder model
// depends on g6d_pkg and the block's top level only

module tb_graph6_stream_decoder_core;
	import g6d_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// one byte of the text stream plus its new-graph flag
	typedef struct packed {
		logic [7:0] value;
		logic       first;
	} stream_byte_t;

	// decoder model phases; the short and long header groups behave alike
	typedef enum logic [2:0] {
		DEC_FIRST,
		DEC_AFTER_TILDE,
		DEC_GROUPS,
		DEC_BODY
	} dec_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  byte_value = '0;
	logic        start_graph = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  result_kind;
	logic [35:0] vertex_count;
	logic [35:0] edge_row;
	logic [35:0] edge_column;
	logic        last_of_run;

	// stream bytes not yet offered, and decoder words still owed by the block
	stream_byte_t stream_q[$];
	res_t         expected_words[$];

	// decoder model state
	dec_phase_t  dec_phase = DEC_FIRST;
	logic [2:0]  groups_left = '0;
	logic [35:0] count_acc = '0;
	logic [35:0] vertex_total = '0;
	logic [35:0] walk_row = '0;
	logic [35:0] walk_col = 36'd1;

	int tx_idle_pct = 37;
	int rx_idle_pct = 55;
	int offered_words = 0;
	int fail_count = 0;
	int cycle_count = 0;

	graph6_stream_decoder_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.byte_value   (byte_value),
		.start_graph  (start_graph),
		.empty        (empty),
		.pop          (pop),
		.result_kind  (result_kind),
		.vertex_count (vertex_count),
		.edge_row     (edge_row),
		.edge_column  (edge_column),
		.last_of_run  (last_of_run)
	);

	always #6 clk = ~clk;

	// header done: latch the count, restart the triangle walk, emit the count word
	function automatic void close_header(input logic [35:0] n);
		res_t w;
		w = '0;
		vertex_total = n;
		count_acc = n;
		walk_row = '0;
		walk_col = 36'd1;
		dec_phase = DEC_BODY;
		groups_left = '0;
		w.kind = KIND_COUNT;
		w.vertex_count = n;
		w.last = 1'b1;
		expected_words.push_back(w);
	endfunction

	// decode one accepted byte and queue every word it should produce
	function automatic void decode_byte(input logic [7:0] b, input logic first);
		res_t       w;
		res_t       held;
		logic       have_held;
		logic [5:0] grp;
		int         k;
		w = '0;
		held = '0;
		have_held = 1'b0;
		// new-graph flag clears the decoder before the byte itself is looked at
		if (first) begin
			dec_phase = DEC_FIRST;
			groups_left = '0;
			count_acc = '0;
			vertex_total = '0;
			walk_row = '0;
			walk_col = 36'd1;
		end
		// whitespace leaves everything alone, in any phase
		if (b == BYTE_SPACE || (b >= BYTE_TAB && b <= BYTE_CR))
			return;
		// anything else outside the printable range is flagged, state untouched
		if (b < BYTE_BIAS || b > BYTE_TILDE) begin
			w.kind = KIND_BAD;
			w.last = 1'b1;
			expected_words.push_back(w);
			return;
		end
		grp = 6'(b - BYTE_BIAS);
		case (dec_phase)
			DEC_FIRST: begin
				if (b == BYTE_TILDE)
					dec_phase = DEC_AFTER_TILDE;
				else
					close_header(36'(grp));
			end
			DEC_AFTER_TILDE: begin
				dec_phase = DEC_GROUPS;
				// a second tilde selects the six-group form
				if (b == BYTE_TILDE) begin
					count_acc = '0;
					groups_left = LONG_LEFT;
				end else begin
					count_acc = 36'(grp);
					groups_left = SHORT_LEFT;
				end
			end
			DEC_GROUPS: begin
				// 36 bits hold every six-group count, so no saturation is reachable
				count_acc = {count_acc[29:0], grp};
				groups_left = groups_left - 3'd1;
				if (groups_left == 3'd0)
					close_header(count_acc);
			end
			default: begin
				// six adjacency bits, msb first, along the upper triangle by column
				for (k = BITS_PER_BYTE - 1; k >= 0; k--) begin
					if (walk_col < vertex_total) begin
						if (grp[k]) begin
							if (have_held)
								expected_words.push_back(held);
							held = '0;
							held.kind = KIND_EDGE;
							held.edge_row = walk_row;
							held.edge_column = walk_col;
							have_held = 1'b1;
						end
						walk_row = walk_row + 36'd1;
						if (walk_row == walk_col) begin
							walk_col = walk_col + 36'd1;
							walk_row = '0;
						end
					end
				end
				// the final edge of this byte carries the run marker
				if (have_held) begin
					held.last = 1'b1;
					expected_words.push_back(held);
				end
			end
		endcase
	endfunction

	// sender: offers queued bytes, holds a byte until it is taken, idles at random
	always @(posedge clk) begin : sender
		stream_byte_t nxt;
		if (arst_n) begin
			if (push && !full)
				decode_byte(byte_value, start_graph);
			if (!(push && full)) begin
				if (stream_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					nxt = stream_q.pop_front();
					push <= 1'b1;
					byte_value <= nxt.value;
					start_graph <= nxt.first;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	task automatic report_field(input string field, input logic [35:0] want,
		input logic [35:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	// receiver: compares every taken word with the oldest expected one
	always @(posedge clk) begin : receiver
		res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual kind %0h",
						$time, result_kind);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					report_field("result_kind", 36'(want.kind), 36'(result_kind));
					report_field("vertex_count", want.vertex_count, vertex_count);
					report_field("edge_row", want.edge_row, edge_row);
					report_field("edge_column", want.edge_column, edge_column);
					report_field("last_of_run", 36'(want.last), 36'(last_of_run));
				end
			end
			pop <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("graph6_stream_decoder_core test failed");
			$finish;
		end
	end

	// whitespace is skipped by the block, so it does not count as real stimulus
	task automatic add_byte(input logic [7:0] b, input logic first);
		stream_byte_t s;
		s.value = b;
		s.first = first;
		stream_q.push_back(s);
		if (!(b == BYTE_SPACE || (b >= BYTE_TAB && b <= BYTE_CR)))
			offered_words++;
	endtask

	// random graphs until the word count reaches target; mostly well-formed,
	// with stray whitespace, bad bytes, missing start flags and cut headers
	task automatic add_random_graphs(input int target);
		logic [35:0] n;
		logic [7:0]  hdr[$];
		logic [7:0]  noise;
		logic [5:0]  mask;
		int          sel, form, nb, nn, i, cut;
		while (offered_words < target) begin
			hdr.delete();
			sel = $urandom_range(99);
			form = 0;
			if (sel < 70) begin
				n = 36'($urandom_range(20));
			end else if (sel < 78) begin
				n = 36'($urandom_range(62, 21));
			end else if (sel < 88) begin
				form = 1;
				n = ($urandom_range(3) == 0) ? 36'($urandom_range(20)) :
					36'($urandom_range(258047));
			end else begin
				form = 2;
				n = ($urandom_range(3) == 0) ? 36'($urandom_range(20)) :
					{4'($urandom), 32'($urandom)};
			end
			if (form == 0) begin
				hdr.push_back(BYTE_BIAS + 8'(n[5:0]));
			end else begin
				hdr.push_back(BYTE_TILDE);
				if (form == 2)
					hdr.push_back(BYTE_TILDE);
				for (i = (form == 2) ? 5 : 2; i >= 0; i--)
					hdr.push_back(BYTE_BIAS + 8'((n >> (6 * i)) & 36'h3f));
			end
			// now and then a header is cut short
			cut = (form != 0 && $urandom_range(19) == 0) ? $urandom_range(3, 1) : 0;
			while (cut > 0 && hdr.size() > 1) begin
				hdr.delete(hdr.size() - 1);
				cut--;
			end
			// a missing start flag lets the old graph swallow the header as body
			for (i = 0; i < hdr.size(); i++)
				add_byte(hdr[i], i == 0 && $urandom_range(99) >= 8);
			// small graphs get a full body give or take; big ones a short slice
			if (n <= 36'd20) begin
				nn = int'(n);
				nb = (nn * (nn - 1) / 2 + 5) / 6;
				sel = $urandom_range(9);
				if (sel == 0)
					nb = nb / 2;
				else if (sel == 1)
					nb = nb + $urandom_range(3, 1);
			end else begin
				nb = $urandom_range(6, 1);
			end
			mask = ($urandom_range(4) == 0) ? 6'h3f : 6'($urandom);
			for (i = 0; i < nb; i++) begin
				if ($urandom_range(99) < 6) begin
					if ($urandom_range(1) == 1)
						noise = ($urandom_range(5) == 5) ? BYTE_SPACE :
							BYTE_TAB + 8'($urandom_range(4));
					else if ($urandom_range(1) == 1)
						noise = 8'($urandom_range(62));
					else
						noise = 8'($urandom_range(255, 127));
					add_byte(noise, $urandom_range(99) == 0);
				end
				add_byte(BYTE_BIAS + 8'(6'($urandom) & mask), 1'b0);
			end
		end
	endtask

	// the test waits until every byte is taken and every word has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (stream_q.size() != 0 || push || expected_words.size() != 0);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: an empty graph with a surplus body byte, then a single-vertex graph
		add_byte(BYTE_BIAS, 1'b1);
		add_byte(BYTE_TILDE, 1'b0);
		add_byte(BYTE_BIAS + 8'd1, 1'b1);
		// bad bytes at both ends of the byte range
		add_byte(8'd0, 1'b0);
		add_byte(8'd255, 1'b0);
		// two vertices, the one edge set, then padding that must stay silent
		add_byte(BYTE_BIAS + 8'd2, 1'b1);
		add_byte(BYTE_BIAS + 8'd32, 1'b0);
		add_byte(BYTE_TILDE, 1'b0);
		// start flag on whitespace resets and is skipped; then a full K4
		add_byte(BYTE_SPACE, 1'b1);
		add_byte(BYTE_BIAS + 8'd4, 1'b0);
		add_byte(BYTE_TILDE, 1'b0);
		add_byte(BYTE_TAB, 1'b0);
		// four-byte header with whitespace inside: 64 vertices
		add_byte(BYTE_TILDE, 1'b1);
		add_byte(BYTE_CR, 1'b0);
		add_byte(BYTE_BIAS, 1'b0);
		add_byte(BYTE_BIAS + 8'd1, 1'b0);
		add_byte(BYTE_BIAS, 1'b0);
		add_byte(BYTE_TILDE, 1'b0);
		// eight-byte header of all ones: the largest count
		add_byte(BYTE_TILDE, 1'b1);
		for (int i = 0; i < 7; i++)
			add_byte(BYTE_TILDE, 1'b0);
		add_byte(BYTE_TILDE, 1'b0);

		// both sides stall, receiver more
		add_random_graphs(offered_words + 110);
		wait_drained();

		// both sides stall, sender more
		tx_idle_pct = 55;
		rx_idle_pct = 37;
		add_random_graphs(offered_words + 110);
		wait_drained();

		// full rate on both sides
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		add_random_graphs(offered_words + 110);
		wait_drained();

		// catch any stray word still coming out of the pipe
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("graph6_stream_decoder_core test passed");
		else
			$display("graph6_stream_decoder_core test failed");
		$finish;
	end

endmodule
